FILE: design/rti_pkg.sv
// Shared types and constants for the ray / triangle intersection unit.
// No dependencies.
package rti_pkg;

	localparam int CW_DEF  = 16;
	localparam int FIELD_W = 48;
	localparam int DIST_W  = 32;
	localparam int BARY_W  = 17;
	localparam int EPS_W   = 24;
	localparam int APB_DW  = 32;
	localparam int APB_AW  = 3;
	localparam int TQ_W    = 48;   // distance quotient bits (Q16.16 magnitude up to 2^48)

	localparam logic [EPS_W-1:0]  EPS_RST  = 24'd17;
	localparam logic [BARY_W-1:0] BARY_ONE = 17'h10000;

	// register index (paddr[2])
	localparam logic [0:0] REG_DET_EPS = 1'b0;

	// result status codes
	localparam logic [2:0] ST_HIT      = 3'd0;
	localparam logic [2:0] ST_PARALLEL = 3'd1;
	localparam logic [2:0] ST_U_OUT    = 3'd2;
	localparam logic [2:0] ST_V_OUT    = 3'd3;
	localparam logic [2:0] ST_T_OUT    = 3'd4;

	typedef struct packed {
		logic [FIELD_W-1:0]        ray_origin;
		logic [FIELD_W-1:0]        ray_direction;
		logic [FIELD_W-1:0]        vertex_a;
		logic [FIELD_W-1:0]        vertex_b;
		logic [FIELD_W-1:0]        vertex_c;
		logic signed [DIST_W-1:0]  t_lower;
		logic signed [DIST_W-1:0]  t_upper;
	} req_t;

	typedef struct packed {
		logic                      hit;
		logic [2:0]                status;
		logic signed [DIST_W-1:0]  hit_distance;
		logic [BARY_W-1:0]         bary_u;
		logic [BARY_W-1:0]         bary_v;
	} rsp_t;

	// flags riding along the distance divider
	typedef struct packed {
		logic                      par;
		logic                      bad_u;
		logic                      bad_v;
		logic                      sat;
		logic                      tneg;
		logic signed [DIST_W-1:0]  tl;
		logic signed [DIST_W-1:0]  tu;
	} tside_t;

	// clamp flags riding along a barycentric divider
	typedef struct packed {
		logic neg;
		logic over;
	} bside_t;

endpackage

FILE: design/rti_div.sv
// Pipelined restoring divider, one quotient bit per stage, padded to LAT stages.
// Standalone; sideband is an opaque vector.
module rti_div #(
	parameter int DW  = 8,
	parameter int QB  = 4,
	parameter int LAT = 4,
	parameter int SBW = 1
) (
	input  logic           clk,
	input  logic           en,
	input  logic [DW-1:0]  den,
	input  logic [DW-1:0]  rem0,
	input  logic [QB-1:0]  nbits,
	input  logic [SBW-1:0] sb_in,
	output logic [QB-1:0]  quo,
	output logic           inexact,
	output logic [SBW-1:0] sb_out
);

	logic [DW-1:0]  rem_s [0:LAT];
	logic [QB-1:0]  quo_s [0:LAT];
	logic [QB-1:0]  nb_s  [0:LAT];
	logic [DW-1:0]  den_s [0:LAT];
	logic [SBW-1:0] sb_s  [0:LAT];

	assign rem_s[0] = rem0;
	assign quo_s[0] = '0;
	assign nb_s[0]  = nbits;
	assign den_s[0] = den;
	assign sb_s[0]  = sb_in;

	for (genvar k = 0; k < LAT; k++) begin : g_st
		if (k < QB) begin : g_step
			logic [DW:0] rs;
			logic        ge;
			assign rs = {rem_s[k], nb_s[k][QB-1]};
			assign ge = rs >= {1'b0, den_s[k]};
			always_ff @(posedge clk) begin
				if (en) begin
					rem_s[k+1] <= ge ? DW'(rs - {1'b0, den_s[k]}) : rs[DW-1:0];
					quo_s[k+1] <= {quo_s[k][QB-2:0], ge};
					nb_s[k+1]  <= nb_s[k] << 1;
					den_s[k+1] <= den_s[k];
					sb_s[k+1]  <= sb_s[k];
				end
			end
		end else begin : g_pass
			always_ff @(posedge clk) begin
				if (en) begin
					rem_s[k+1] <= rem_s[k];
					quo_s[k+1] <= quo_s[k];
					nb_s[k+1]  <= nb_s[k];
					den_s[k+1] <= den_s[k];
					sb_s[k+1]  <= sb_s[k];
				end
			end
		end
	end

	assign quo     = quo_s[LAT];
	assign inexact = |rem_s[LAT];
	assign sb_out  = sb_s[LAT];

endmodule

FILE: design/ray_triangle_intersect.sv
// Moller-Trumbore ray / triangle intersection, exact fixed point, fully pipelined.
// Pipeline: 7 arithmetic stages, 48 divider stages and 1 output register lie between
// an accepted request beat and its response beat.
// Throughput: one beat per cycle; the whole pipe freezes only while the output
// register holds a beat that is stalled. Reset clears all valid bits and sets
// det_epsilon to 17. Depends on rti_pkg and rti_div.
module ray_triangle_intersect import rti_pkg::*; #(
	parameter int COORD_WIDTH = CW_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	// request channel
	input  logic               req_valid,
	output logic               req_stall,
	input  req_t               req,
	// response channel
	output logic               rsp_valid,
	input  logic               rsp_stall,
	output rsp_t               rsp,
	// register port
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [APB_AW-1:0]  paddr,
	input  logic [APB_DW-1:0]  pwdata,
	output logic [APB_DW-1:0]  prdata,
	output logic               pready
);

	// Packed fields hold 48 bits, so components never exceed 16 bits.
	localparam int CWE = (COORD_WIDTH > 16) ? 16 : COORD_WIDTH;
	localparam int EW  = CWE + 1;      // edges / offsets
	localparam int PW  = 2 * EW;       // first products
	localparam int HW  = PW + 1;       // cross product terms
	localparam int P2W = EW + HW;      // second products
	localparam int SMW = P2W + 2;      // dot products (signed)
	localparam int DW  = SMW;          // |det| and |T|
	localparam int NW  = SMW + 1;      // sign-normalized numerators
	localparam int LAT = TQ_W;         // divider depth

	function automatic logic signed [EW-1:0] comp(input logic [FIELD_W-1:0] p, input int idx);
		logic [CWE-1:0] raw;
		raw = p[idx*CWE +: CWE];
		return EW'(signed'(raw));
	endfunction

	// ---------------------------------------------------------------
	// Register port
	// ---------------------------------------------------------------
	logic [EPS_W-1:0] eps_q;
	logic [0:0]       reg_idx;

	assign reg_idx = paddr[APB_AW-1:2];
	assign pready  = 1'b1;
	assign prdata  = (reg_idx == REG_DET_EPS) ? APB_DW'(eps_q) : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			eps_q <= EPS_RST;
		end else if (psel && penable && pwrite && reg_idx == REG_DET_EPS) begin
			eps_q <= pwdata[EPS_W-1:0];
		end
	end

	// ---------------------------------------------------------------
	// Flow control: one global advance, frozen only by a stalled output.
	// ---------------------------------------------------------------
	logic en;
	logic rsp_valid_q;
	rsp_t rsp_q;

	assign en        = !(rsp_valid_q && rsp_stall);
	assign req_stall = !en;

	logic v_s1, v_s2, v_s3, v_s4, v_s5, v_s6, v_s7;
	logic vdiv_q [LAT];

	// ---------------------------------------------------------------
	// S1: unpack, edges e1 = b - a, e2 = c - a, s = o - a
	// ---------------------------------------------------------------
	logic signed [EW-1:0] d_s1 [3], e1_s1 [3], e2_s1 [3], s_s1 [3];
	logic signed [DIST_W-1:0] tl_s1, tu_s1;

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 3; i++) begin
				d_s1[i]  <= comp(req.ray_direction, i);
				e1_s1[i] <= comp(req.vertex_b, i) - comp(req.vertex_a, i);
				e2_s1[i] <= comp(req.vertex_c, i) - comp(req.vertex_a, i);
				s_s1[i]  <= comp(req.ray_origin, i) - comp(req.vertex_a, i);
			end
			tl_s1 <= req.t_lower;
			tu_s1 <= req.t_upper;
		end
	end

	// ---------------------------------------------------------------
	// S2: products for h = d x e2 and q = s x e1
	// ---------------------------------------------------------------
	logic signed [PW-1:0] ph_s2 [6], pq_s2 [6];
	logic signed [EW-1:0] d_s2 [3], e1_s2 [3], e2_s2 [3], s_s2 [3];
	logic signed [DIST_W-1:0] tl_s2, tu_s2;

	always_ff @(posedge clk) begin
		if (en) begin
			ph_s2[0] <= PW'(d_s1[1]) * PW'(e2_s1[2]);
			ph_s2[1] <= PW'(d_s1[2]) * PW'(e2_s1[1]);
			ph_s2[2] <= PW'(d_s1[2]) * PW'(e2_s1[0]);
			ph_s2[3] <= PW'(d_s1[0]) * PW'(e2_s1[2]);
			ph_s2[4] <= PW'(d_s1[0]) * PW'(e2_s1[1]);
			ph_s2[5] <= PW'(d_s1[1]) * PW'(e2_s1[0]);
			pq_s2[0] <= PW'(s_s1[1]) * PW'(e1_s1[2]);
			pq_s2[1] <= PW'(s_s1[2]) * PW'(e1_s1[1]);
			pq_s2[2] <= PW'(s_s1[2]) * PW'(e1_s1[0]);
			pq_s2[3] <= PW'(s_s1[0]) * PW'(e1_s1[2]);
			pq_s2[4] <= PW'(s_s1[0]) * PW'(e1_s1[1]);
			pq_s2[5] <= PW'(s_s1[1]) * PW'(e1_s1[0]);
			d_s2  <= d_s1;
			e1_s2 <= e1_s1;
			e2_s2 <= e2_s1;
			s_s2  <= s_s1;
			tl_s2 <= tl_s1;
			tu_s2 <= tu_s1;
		end
	end

	// ---------------------------------------------------------------
	// S3: cross product differences
	// ---------------------------------------------------------------
	logic signed [HW-1:0] h_s3 [3], q_s3 [3];
	logic signed [EW-1:0] d_s3 [3], e1_s3 [3], e2_s3 [3], s_s3 [3];
	logic signed [DIST_W-1:0] tl_s3, tu_s3;

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 3; i++) begin
				h_s3[i] <= HW'(ph_s2[2*i]) - HW'(ph_s2[2*i+1]);
				q_s3[i] <= HW'(pq_s2[2*i]) - HW'(pq_s2[2*i+1]);
			end
			d_s3  <= d_s2;
			e1_s3 <= e1_s2;
			e2_s3 <= e2_s2;
			s_s3  <= s_s2;
			tl_s3 <= tl_s2;
			tu_s3 <= tu_s2;
		end
	end

	// ---------------------------------------------------------------
	// S4: products for det = e1.h, U = s.h, V = d.q, T = e2.q
	// ---------------------------------------------------------------
	logic signed [P2W-1:0] pd_s4 [3], pu_s4 [3], pv_s4 [3], pt_s4 [3];
	logic signed [DIST_W-1:0] tl_s4, tu_s4;

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 3; i++) begin
				pd_s4[i] <= P2W'(e1_s3[i]) * P2W'(h_s3[i]);
				pu_s4[i] <= P2W'(s_s3[i])  * P2W'(h_s3[i]);
				pv_s4[i] <= P2W'(d_s3[i])  * P2W'(q_s3[i]);
				pt_s4[i] <= P2W'(e2_s3[i]) * P2W'(q_s3[i]);
			end
			tl_s4 <= tl_s3;
			tu_s4 <= tu_s3;
		end
	end

	// ---------------------------------------------------------------
	// S5: dot product sums
	// ---------------------------------------------------------------
	logic signed [SMW-1:0] det_s5, un_s5, vn_s5, tn_s5;
	logic signed [DIST_W-1:0] tl_s5, tu_s5;

	always_ff @(posedge clk) begin
		if (en) begin
			det_s5 <= SMW'(pd_s4[0]) + SMW'(pd_s4[1]) + SMW'(pd_s4[2]);
			un_s5  <= SMW'(pu_s4[0]) + SMW'(pu_s4[1]) + SMW'(pu_s4[2]);
			vn_s5  <= SMW'(pv_s4[0]) + SMW'(pv_s4[1]) + SMW'(pv_s4[2]);
			tn_s5  <= SMW'(pt_s4[0]) + SMW'(pt_s4[1]) + SMW'(pt_s4[2]);
			tl_s5  <= tl_s4;
			tu_s5  <= tu_s4;
		end
	end

	// ---------------------------------------------------------------
	// S6: parallel test, sign normalization so that det > 0
	// ---------------------------------------------------------------
	logic          det_neg, tn_neg;
	logic [DW-1:0] adet, atn;

	assign det_neg = det_s5[SMW-1];
	assign tn_neg  = tn_s5[SMW-1];
	assign adet    = det_neg ? DW'(-det_s5) : DW'(det_s5);
	assign atn     = tn_neg ? DW'(-tn_s5) : DW'(tn_s5);

	logic                  par_s6, tneg_s6;
	logic [DW-1:0]         den_s6, atn_s6;
	logic signed [NW-1:0]  un_s6, vn_s6;
	logic signed [DIST_W-1:0] tl_s6, tu_s6;

	always_ff @(posedge clk) begin
		if (en) begin
			// zero det is parallel even with a zero threshold
			par_s6  <= (det_s5 == '0) ||
				((DW+EPS_W)'(adet) < (DW+EPS_W)'(eps_q));
			den_s6  <= adet;
			atn_s6  <= atn;
			// sign of T after normalization
			tneg_s6 <= (tn_s5 != '0) && (tn_neg != det_neg);
			un_s6   <= det_neg ? -NW'(un_s5) : NW'(un_s5);
			vn_s6   <= det_neg ? -NW'(vn_s5) : NW'(vn_s5);
			tl_s6   <= tl_s5;
			tu_s6   <= tu_s5;
		end
	end

	// ---------------------------------------------------------------
	// S7: range flags, distance overflow check, divider set-up
	// ---------------------------------------------------------------
	logic signed [NW-1:0] den_sx;
	logic signed [NW:0]   uv_sum;
	logic [DW+63:0]       tnum_x;
	logic                 u_neg, u_over, v_neg, v_over;

	assign den_sx = signed'({1'b0, den_s6});
	assign uv_sum = (NW+1)'(un_s6) + (NW+1)'(vn_s6);
	assign tnum_x = (DW+64)'(atn_s6) << 16;
	assign u_neg  = un_s6[NW-1];
	assign v_neg  = vn_s6[NW-1];
	assign u_over = un_s6 > den_sx;
	assign v_over = vn_s6 > den_sx;

	logic [DW-1:0]     den_s7, t_r0_s7, u_r0_s7, v_r0_s7;
	logic [TQ_W-1:0]   t_nb_s7;
	logic [BARY_W-1:0] u_nb_s7, v_nb_s7;
	tside_t            ts_s7;
	bside_t            us_s7, vs_s7;

	always_ff @(posedge clk) begin
		if (en) begin
			den_s7     <= den_s6;
			// T * 2^16 / det: integer part at or above 2^32 saturates
			ts_s7.sat  <= (DW+32)'(atn_s6) >= {den_s6, 32'd0};
			ts_s7.par  <= par_s6;
			ts_s7.bad_u <= u_neg || u_over;
			ts_s7.bad_v <= v_neg || (uv_sum > (NW+1)'(den_sx));
			ts_s7.tneg <= tneg_s6;
			ts_s7.tl   <= tl_s6;
			ts_s7.tu   <= tu_s6;
			t_r0_s7    <= DW'(tnum_x >> TQ_W);
			t_nb_s7    <= tnum_x[TQ_W-1:0];
			// in-range U, V give a quotient of at most 2^16
			u_r0_s7    <= DW'(un_s6 >>> 1);
			u_nb_s7    <= {un_s6[0], 16'd0};
			v_r0_s7    <= DW'(vn_s6 >>> 1);
			v_nb_s7    <= {vn_s6[0], 16'd0};
			us_s7      <= '{neg: u_neg, over: u_over};
			vs_s7      <= '{neg: v_neg, over: v_over};
		end
	end

	// ---------------------------------------------------------------
	// Dividers: all three run LAT stages so their results line up.
	// ---------------------------------------------------------------
	logic [TQ_W-1:0]          t_quo;
	logic                     t_inx, u_inx, v_inx;
	logic [$bits(tside_t)-1:0] t_sb;
	logic [BARY_W-1:0]        u_quo, v_quo;
	logic [$bits(bside_t)-1:0] u_sb, v_sb;

	rti_div #(.DW(DW), .QB(TQ_W), .LAT(LAT), .SBW($bits(tside_t))) u_div_t (
		.clk(clk), .en(en), .den(den_s7), .rem0(t_r0_s7), .nbits(t_nb_s7),
		.sb_in(ts_s7), .quo(t_quo), .inexact(t_inx), .sb_out(t_sb)
	);

	rti_div #(.DW(DW), .QB(BARY_W), .LAT(LAT), .SBW($bits(bside_t))) u_div_u (
		.clk(clk), .en(en), .den(den_s7), .rem0(u_r0_s7), .nbits(u_nb_s7),
		.sb_in(us_s7), .quo(u_quo), .inexact(u_inx), .sb_out(u_sb)
	);

	rti_div #(.DW(DW), .QB(BARY_W), .LAT(LAT), .SBW($bits(bside_t))) u_div_v (
		.clk(clk), .en(en), .den(den_s7), .rem0(v_r0_s7), .nbits(v_nb_s7),
		.sb_in(vs_s7), .quo(v_quo), .inexact(v_inx), .sb_out(v_sb)
	);

	// ---------------------------------------------------------------
	// Final: distance test on the exact quotient, saturation, clamps
	// ---------------------------------------------------------------
	tside_t                  ts;
	bside_t                  us, vs;
	logic [TQ_W:0]           mag;
	logic                    ix, lo_ok, hi_ok;
	logic signed [TQ_W+1:0]  smag, sd, tl_x, tu_x;
	logic [DIST_W-1:0]       dist_sat;
	logic [BARY_W-1:0]       bu, bv;
	rsp_t                    res;

	assign ts   = tside_t'(t_sb);
	assign us   = bside_t'(u_sb);
	assign vs   = bside_t'(v_sb);
	assign mag  = ts.sat ? (TQ_W+1)'(1) << TQ_W : {1'b0, t_quo};
	assign ix   = ts.sat || t_inx;
	assign smag = signed'({1'b0, mag});
	assign sd   = ts.tneg ? -smag : smag;
	assign tl_x = (TQ_W+2)'(ts.tl);
	assign tu_x = (TQ_W+2)'(ts.tu);
	// a truncated quotient equal to a bound still lies past it when inexact
	assign lo_ok = (sd > tl_x) || (!ts.tneg && sd == tl_x && ix);
	assign hi_ok = (sd < tu_x) || (ts.tneg && sd == tu_x && ix);
	assign bu = us.neg ? '0 : (us.over ? BARY_ONE : u_quo);
	assign bv = vs.neg ? '0 : (vs.over ? BARY_ONE : v_quo);

	always_comb begin
		if (ts.tneg) begin
			dist_sat = (mag > (TQ_W+1)'(33'h1_0000_0000 >> 1)) ? 32'h8000_0000
				: DIST_W'((TQ_W+1)'(0) - mag);
		end else begin
			dist_sat = (mag > (TQ_W+1)'(32'h7FFF_FFFF)) ? 32'h7FFF_FFFF
				: mag[DIST_W-1:0];
		end
	end

	always_comb begin
		res.hit          = 1'b0;
		res.hit_distance = signed'(dist_sat);
		res.bary_u       = bu;
		res.bary_v       = bv;
		priority if (ts.par) begin
			res.status       = ST_PARALLEL;
			res.hit_distance = '0;
			res.bary_u       = '0;
			res.bary_v       = '0;
		end else if (ts.bad_u) begin
			res.status = ST_U_OUT;
		end else if (ts.bad_v) begin
			res.status = ST_V_OUT;
		end else if (!(lo_ok && hi_ok)) begin
			res.status = ST_T_OUT;
		end else begin
			res.status = ST_HIT;
			res.hit    = 1'b1;
		end
	end

	// ---------------------------------------------------------------
	// Valid chain and output register
	// ---------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
			v_s7 <= 1'b0;
			for (int k = 0; k < LAT; k++) begin
				vdiv_q[k] <= 1'b0;
			end
			rsp_valid_q <= 1'b0;
		end else if (en) begin
			v_s1 <= req_valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
			v_s6 <= v_s5;
			v_s7 <= v_s6;
			vdiv_q[0] <= v_s7;
			for (int k = 1; k < LAT; k++) begin
				vdiv_q[k] <= vdiv_q[k-1];
			end
			rsp_valid_q <= vdiv_q[LAT-1];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			rsp_q <= res;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	// ---------------------------------------------------------------
	// Checks
	// ---------------------------------------------------------------
	a_hit_status: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> (rsp.hit == (rsp.status == ST_HIT)))
		else $error("hit flag disagrees with status");

	a_par_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid && rsp.status == ST_PARALLEL) |->
		(rsp.hit_distance == '0 && rsp.bary_u == '0 && rsp.bary_v == '0))
		else $error("parallel result carries nonzero data");

	a_bary_range: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> (rsp.bary_u <= BARY_ONE && rsp.bary_v <= BARY_ONE))
		else $error("barycentric coordinate out of range");

	a_hit_sum: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid && rsp.status == ST_HIT) |->
		((BARY_W+1)'(rsp.bary_u) + (BARY_W+1)'(rsp.bary_v) <= (BARY_W+1)'(BARY_ONE)))
		else $error("hit with u + v above one");

	// unused remainder flags of the barycentric dividers (truncation only)
	logic bary_inx_unused;
	assign bary_inx_unused = u_inx ^ v_inx;

endmodule
